>>> hdl/variable_partition_allocator_unit_macros.svh
// assertion macros for the free-hole allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define VPA_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("allocator check failed");

// pre at one edge implies post at the next edge
`define VPA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("allocator sequence check failed");

`else

`define VPA_ASSERT_ALWAYS(label, cond)
`define VPA_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> hdl/vpa_pkg.sv
// shared constants, types and codes of the free-hole allocator
`default_nettype none

package vpa_pkg;

	localparam int MAX_HOLES     = 16;
	localparam int ADDRESS_WIDTH = 16;

	localparam int IDX_W  = $clog2(MAX_HOLES);
	localparam int CNT_W  = $clog2(MAX_HOLES + 1);
	localparam int FADR_W = 16;
	localparam int LEN_W  = 16;
	localparam int TAG_W  = 8;
	localparam int HL_W   = 5;
	localparam int STAT_W = 2;
	localparam int POL_W  = 2;

	typedef logic [ADDRESS_WIDTH-1:0] addr_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_NO_FIT   = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_ZERO_LEN = 2'd3
	} status_t;

	// policy code 3 falls through to first fit
	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_WORST = 2'd1;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

	typedef struct packed {
		addr_t start;
		len_t  size;
	} hole_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		hole_t data;
	} ram_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_PICK,
		S_SHIFT,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

>>> hdl/vpa_if.sv
// channel interfaces of the free-hole allocator: request, response, policy write
`default_nettype none

interface vpa_req_if import vpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [FADR_W-1:0] hole_address;
	logic [LEN_W-1:0]  length;
	logic [TAG_W-1:0]  job_tag;

	modport source (output valid, func, hole_address, length, job_tag, input ready);
	modport sink (input valid, func, hole_address, length, job_tag, output ready);
endinterface

interface vpa_rsp_if import vpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [FADR_W-1:0] granted_address;
	logic [LEN_W-1:0]  granted_length;
	logic [TAG_W-1:0]  tag_echo;
	logic [HL_W-1:0]   holes_left;

	modport source (output valid, status, granted_address, granted_length, tag_echo,
		holes_left, input ready);
	modport sink (input valid, status, granted_address, granted_length, tag_echo,
		holes_left, output ready);
endinterface

interface vpa_cfg_if import vpa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/vpa_hole_ram.sv
// hole table storage: one write port, one registered read port
`default_nettype none

module vpa_hole_ram import vpa_pkg::*; (
	input  wire logic    clk,
	input  wire ram_wr_t wr,
	input  wire idx_t    raddr,
	output hole_t        rdata
);

	hole_t mem [MAX_HOLES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/variable_partition_allocator_unit.sv
// free-hole allocator top level: sequencer, scan compare unit and result register
//
//   channel | dir | handshake     | beat carries
//   --------+-----+---------------+--------------------------------------------------
//   req     | in  | valid/ready   | func, hole_address, length, job_tag
//   rsp     | out | valid/ready   | status, granted_address, granted_length,
//           |     |               | tag_echo, holes_left
//   cfg     | in  | valid/ready   | fit_policy (always ready)
//
// load: accept, table write, result; zero-length request: accept, result
// allocate: accept, scan of every hole, pick, result; the table read port paces
//   the scan at one entry a cycle; removing an emptied hole adds a shift that moves
//   every entry above it down one place
// one request at a time; req.ready is high only while the sequencer is idle
// a finished beat waits in the rsp register, the next request is taken meanwhile
// reset clears the hole count and the policy; the table needs no clearing
`default_nettype none

`include "variable_partition_allocator_unit_macros.svh"

module variable_partition_allocator_unit import vpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	vpa_req_if.sink   req,
	vpa_rsp_if.source rsp,
	vpa_cfg_if.sink   cfg
);

	state_t state_q, state_nxt;

	logic [POL_W-1:0] policy_q;
	cnt_t             hole_cnt_q;
	cnt_t             rd_idx_q;
	logic             ev_vld_q;
	logic             found_q;
	logic             out_vld_q;

	addr_t   addr_q;
	len_t    len_q;
	logic [TAG_W-1:0] tag_q;
	status_t status_q;
	addr_t   grant_addr_q;
	len_t    grant_len_q;
	idx_t    ev_idx_q;
	idx_t    best_idx_q;
	addr_t   best_start_q;
	len_t    best_size_q;

	status_t          out_status_q;
	logic [FADR_W-1:0] out_addr_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [HL_W-1:0]   out_hl_q;

	ram_wr_t ram_wr;
	idx_t    ram_raddr;
	hole_t   ram_rdata;

	logic  req_acc;
	logic  out_free;
	logic  scan_issue;
	logic  fits;
	logic  take;
	logic  not_full;
	len_t  new_size;
	addr_t new_start;

	// true when hole a beats the current pick b
	function automatic logic better(input logic [POL_W-1:0] pol, input len_t a_size,
			input addr_t a_start, input len_t b_size, input addr_t b_start);
		logic r;
		r = a_start < b_start;
		case (pol)
			POL_WORST: begin
				if (a_size != b_size) r = a_size > b_size;
			end
			POL_BEST: begin
				if (a_size != b_size) r = a_size < b_size;
			end
			default: begin
				r = a_start < b_start;
			end
		endcase
		return r;
	endfunction

	vpa_hole_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req_acc    = req.valid && req.ready;
	assign out_free   = !out_vld_q || rsp.ready;
	assign scan_issue = rd_idx_q < hole_cnt_q;
	assign not_full   = hole_cnt_q < CNT_W'(MAX_HOLES);
	assign fits       = ram_rdata.size >= len_q;
	assign take       = ev_vld_q && fits && (!found_q ||
		better(policy_q, ram_rdata.size, ram_rdata.start, best_size_q, best_start_q));
	assign new_size   = best_size_q - len_q;
	assign new_start  = best_start_q + ADDRESS_WIDTH'(len_q);
	assign ram_raddr  = rd_idx_q[IDX_W-1:0];

	assign cfg.ready           = 1'b1;
	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_status_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.granted_length  = out_len_q;
	assign rsp.tag_echo        = out_tag_q;
	assign rsp.holes_left      = out_hl_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (!req.func) state_nxt = S_LOAD;
					else if (req.length == '0) state_nxt = S_FIN;
					else state_nxt = S_SCAN;
				end
			end
			S_LOAD: begin
				state_nxt = S_FIN;
			end
			S_SCAN: begin
				if (!scan_issue && !ev_vld_q) state_nxt = S_PICK;
			end
			S_PICK: begin
				if (!found_q || new_size != '0) state_nxt = S_FIN;
				else state_nxt = S_SHIFT;
			end
			S_SHIFT: begin
				if (!scan_issue && !ev_vld_q) state_nxt = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_wr    = '0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_LOAD: begin
				ram_wr.en         = not_full;
				ram_wr.addr       = hole_cnt_q[IDX_W-1:0];
				ram_wr.data.start = addr_q;
				ram_wr.data.size  = len_q;
			end
			S_PICK: begin
				ram_wr.en         = found_q && new_size != '0;
				ram_wr.addr       = best_idx_q;
				ram_wr.data.start = new_start;
				ram_wr.data.size  = new_size;
			end
			S_SHIFT: begin
				// entry read last cycle moves down one place
				ram_wr.en   = ev_vld_q;
				ram_wr.addr = ev_idx_q - IDX_W'(1);
				ram_wr.data = ram_rdata;
			end
			default: begin
				ram_wr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			policy_q   <= POL_FIRST;
			hole_cnt_q <= '0;
			rd_idx_q   <= '0;
			ev_vld_q   <= 1'b0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg.valid) policy_q <= cfg.data;
			// a new beat may load while the previous one leaves
			if (state_q == S_FIN && out_free) out_vld_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						rd_idx_q <= '0;
						ev_vld_q <= 1'b0;
						found_q  <= 1'b0;
					end
				end
				S_LOAD: begin
					if (not_full) hole_cnt_q <= hole_cnt_q + CNT_W'(1);
				end
				S_SCAN: begin
					ev_vld_q <= scan_issue;
					if (scan_issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
					if (take) found_q <= 1'b1;
				end
				S_PICK: begin
					rd_idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
					ev_vld_q <= 1'b0;
				end
				S_SHIFT: begin
					ev_vld_q <= scan_issue;
					if (scan_issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
					if (!scan_issue && !ev_vld_q) hole_cnt_q <= hole_cnt_q - CNT_W'(1);
				end
				default: begin
					ev_vld_q <= 1'b0;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					addr_q       <= ADDRESS_WIDTH'(req.hole_address);
					len_q        <= req.length;
					tag_q        <= req.job_tag;
					grant_addr_q <= '0;
					grant_len_q  <= '0;
					status_q     <= (req.func && req.length == '0) ? STAT_ZERO_LEN : STAT_DONE;
				end
			end
			S_LOAD: begin
				if (!not_full) status_q <= STAT_FULL;
			end
			S_SCAN: begin
				ev_idx_q <= rd_idx_q[IDX_W-1:0];
				if (take) begin
					best_idx_q   <= ev_idx_q;
					best_start_q <= ram_rdata.start;
					best_size_q  <= ram_rdata.size;
				end
			end
			S_PICK: begin
				if (!found_q) begin
					status_q <= STAT_NO_FIT;
				end else begin
					grant_addr_q <= best_start_q;
					grant_len_q  <= len_q;
				end
			end
			S_SHIFT: begin
				ev_idx_q <= rd_idx_q[IDX_W-1:0];
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_addr_q   <= FADR_W'(grant_addr_q);
					out_len_q    <= grant_len_q;
					out_tag_q    <= tag_q;
					out_hl_q     <= HL_W'(hole_cnt_q);
				end
			end
			default: begin
				ev_idx_q <= ev_idx_q;
			end
		endcase
	end

	`VPA_ASSERT_ALWAYS(a_cnt_bound, hole_cnt_q <= CNT_W'(MAX_HOLES))
	`VPA_ASSERT_NEXT(a_busy_after_accept, req_acc, !req.ready)
	`VPA_ASSERT_NEXT(a_load_grows, state_q == S_LOAD && not_full,
		hole_cnt_q == $past(hole_cnt_q) + CNT_W'(1))
	`VPA_ASSERT_NEXT(a_shift_shrinks, state_q == S_SHIFT && state_nxt == S_FIN,
		hole_cnt_q == $past(hole_cnt_q) - CNT_W'(1))
	`VPA_ASSERT_NEXT(a_grant_only_done, state_q == S_FIN && out_free && grant_len_q != '0,
		rsp.valid && rsp.status == STAT_DONE)

endmodule

`default_nettype wire

>>> sim/variable_partition_allocator_unit_tb.sv
// testbench of the free-hole allocator: directed table, then random load/allocate phases
`timescale 1ns / 1ps

module variable_partition_allocator_unit_tb;
	import vpa_pkg::*;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;
	// unused policy code, behaves as first fit
	localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 120;
	// longest allocate is a full scan plus a full shift
	localparam int DRAIN_CYCLES = 40;
	localparam int QUIET_LIMIT  = 2000;
	localparam int MAX_PRINTS   = 60;

	typedef struct packed {
		status_t          status;
		addr_t            addr;
		len_t             len;
		logic [TAG_W-1:0] tag;
		logic [HL_W-1:0]  holes;
	} grant_t;

	typedef struct packed {
		logic             is_policy;
		logic [POL_W-1:0] policy;
		logic             fn;
		addr_t            addr;
		len_t             len;
		logic [TAG_W-1:0] tag;
		logic [4:0]       reps;
		logic             pinned;
		grant_t           want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	vpa_req_if req_ch ();
	vpa_rsp_if rsp_ch ();
	vpa_cfg_if cfg_ch ();

	variable_partition_allocator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// hole table as the block should hold it
	addr_t            free_start [MAX_HOLES];
	len_t             free_size  [MAX_HOLES];
	int               free_count = 0;
	logic [POL_W-1:0] fit_mode   = POL_FIRST;

	grant_t grants_due [$];
	logic   pin_on;
	grant_t pin_want;
	int     burst_left   = 0;
	int     quiet_cycles = 0;
	int     mismatches   = 0;
	bit     hold_ask     = 1'b0;

	function automatic bit prefer(int i, int j);
		if (fit_mode == POL_WORST && free_size[i] != free_size[j])
			return free_size[i] > free_size[j];
		if (fit_mode == POL_BEST && free_size[i] != free_size[j])
			return free_size[i] < free_size[j];
		return free_start[i] < free_start[j];
	endfunction

	function automatic grant_t fit_and_grant(logic fn, addr_t a, len_t l,
			logic [TAG_W-1:0] t);
		grant_t g;
		int     pick;
		int     i;
		g = '{STAT_DONE, '0, '0, t, '0};
		if (fn == FUNC_LOAD) begin
			if (free_count >= MAX_HOLES) begin
				g.status = STAT_FULL;
			end else begin
				free_start[free_count] = a;
				free_size[free_count]  = l;
				free_count++;
			end
		end else if (l == '0) begin
			g.status = STAT_ZERO_LEN;
		end else begin
			pick = -1;
			for (i = 0; i < free_count; i++)
				if (free_size[i] >= l && (pick < 0 || prefer(i, pick)))
					pick = i;
			if (pick < 0) begin
				g.status = STAT_NO_FIT;
			end else begin
				g.addr = free_start[pick];
				g.len  = l;
				// start wraps at the address width
				free_start[pick] = free_start[pick] + l;
				free_size[pick]  = free_size[pick] - l;
				if (free_size[pick] == '0) begin
					for (i = pick; i + 1 < free_count; i++) begin
						free_start[i] = free_start[i + 1];
						free_size[i]  = free_size[i + 1];
					end
					free_count--;
				end
			end
		end
		g.holes = HL_W'(free_count);
		return g;
	endfunction

	function automatic plan_row_t step_row(logic fn, addr_t a, len_t l,
			logic [TAG_W-1:0] t, int reps);
		plan_row_t row;
		row      = '0;
		row.fn   = fn;
		row.addr = a;
		row.len  = l;
		row.tag  = t;
		row.reps = 5'(reps);
		return row;
	endfunction

	function automatic plan_row_t pinned_row(logic fn, addr_t a, len_t l,
			logic [TAG_W-1:0] t, status_t st, int holes);
		plan_row_t row;
		row        = step_row(fn, a, l, t, 1);
		row.pinned = 1'b1;
		row.want   = '{st, '0, '0, t, HL_W'(holes)};
		return row;
	endfunction

	function automatic plan_row_t policy_row(logic [POL_W-1:0] p);
		plan_row_t row;
		row           = '0;
		row.is_policy = 1'b1;
		row.policy    = p;
		return row;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch on %s at %0t ns: got %0h, want %0h", what, $time, got, want);
		mismatches++;
	endtask

	task automatic offer(input logic fn, input addr_t a, input len_t l,
			input logic [TAG_W-1:0] t, input logic pin, input grant_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.func         <= fn;
		req_ch.hole_address <= a;
		req_ch.length       <= l;
		req_ch.job_tag      <= t;
		pin_on              <= pin;
		pin_want            <= want;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// stop offering and wait until every awaited beat is back
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (grants_due.size() != 0);
	endtask

	task automatic write_policy(input logic [POL_W-1:0] p);
		quiesce();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= p;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin : beat_monitor
		grant_t got;
		grant_t want;
		if (arst_n) begin
			got = {rsp_ch.status, rsp_ch.granted_address, rsp_ch.granted_length,
				rsp_ch.tag_echo, rsp_ch.holes_left};
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (grants_due.size() == 0) begin
					report_mismatch("beat with nothing awaited, tag", got.tag, 0);
				end else begin
					want = grants_due.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.addr !== want.addr)
						report_mismatch("granted_address", got.addr, want.addr);
					if (got.len !== want.len)
						report_mismatch("granted_length", got.len, want.len);
					if (got.tag !== want.tag)
						report_mismatch("tag_echo", got.tag, want.tag);
					if (got.holes !== want.holes)
						report_mismatch("holes_left", got.holes, want.holes);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				fit_mode = cfg_ch.data;
			if (req_ch.valid && req_ch.ready) begin
				want = fit_and_grant(req_ch.func, req_ch.hole_address, req_ch.length,
					req_ch.job_tag);
				if (pin_on)
					want = pin_want;
				grants_due.push_back(want);
			end
			if ((rsp_ch.valid && rsp_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
					|| (req_ch.valid && req_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// response side: ready stretches, random ready, short stalls, one long hold-off
	initial begin : response_sink
		int n;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_ask) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_ask = 1'b0;
			end else begin
				n = $urandom_range(1, 24);
				case ($urandom_range(0, 3))
					0, 1: begin
						rsp_ch.ready <= 1'b1;
						repeat (n) @(posedge clk);
					end
					2: begin
						repeat (n) begin
							rsp_ch.ready <= 1'($urandom_range(0, 1));
							@(posedge clk);
						end
					end
					default: begin
						rsp_ch.ready <= 1'b0;
						repeat ((n + 3) / 4) @(posedge clk);
					end
				endcase
			end
		end
	end

	initial begin : stimulus
		plan_row_t        plan [$];
		int               k;
		int               r;
		int               sent;
		int               phase_end;
		int               load_pct;
		logic             fn;
		addr_t            a;
		len_t             l;
		logic [TAG_W-1:0] t;

		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.func         = FUNC_LOAD;
		req_ch.hole_address = '0;
		req_ch.length       = '0;
		req_ch.job_tag      = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = POL_FIRST;
		pin_on              = 1'b0;
		pin_want            = '0;

		// empty table: nothing fits, a zero request is flagged
		plan.push_back(pinned_row(FUNC_ALLOC, 16'h0000, 16'd5, 8'h01, STAT_NO_FIT, 0));
		plan.push_back(pinned_row(FUNC_ALLOC, 16'hffff, 16'd0, 8'hff, STAT_ZERO_LEN, 0));
		plan.push_back(pinned_row(FUNC_LOAD, 16'hffff, 16'hffff, 8'h00, STAT_DONE, 1));
		// empty hole is stored but never fits
		plan.push_back(pinned_row(FUNC_LOAD, 16'h0000, 16'h0000, 8'h02, STAT_DONE, 2));
		plan.push_back(pinned_row(FUNC_LOAD, 16'h1000, 16'h0010, 8'h03, STAT_DONE, 3));
		plan.push_back(step_row(FUNC_ALLOC, 16'h0000, 16'h0008, 8'h05, 1));
		// largest hole sits at the top, its start wraps
		plan.push_back(policy_row(POL_WORST));
		plan.push_back(step_row(FUNC_ALLOC, 16'h0000, 16'h0002, 8'h06, 1));
		// exact fit empties the hole and removes it
		plan.push_back(policy_row(POL_BEST));
		plan.push_back(step_row(FUNC_ALLOC, 16'h0000, 16'h0008, 8'h07, 1));
		plan.push_back(pinned_row(FUNC_ALLOC, 16'h0000, 16'hffff, 8'h08, STAT_NO_FIT, 2));
		plan.push_back(policy_row(POL_SPARE));
		plan.push_back(step_row(FUNC_ALLOC, 16'h0000, 16'h0001, 8'h09, 1));
		// fill the table with equal holes at falling addresses
		plan.push_back(step_row(FUNC_LOAD, 16'h8000, 16'h0020, 8'h10, 14));
		plan.push_back(pinned_row(FUNC_LOAD, 16'h5555, 16'h0001, 8'haa, STAT_FULL, 16));
		// equal sizes: the lowest address wins, here the last entry
		plan.push_back(policy_row(POL_BEST));
		plan.push_back(step_row(FUNC_ALLOC, 16'h0000, 16'h0020, 8'h20, 1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < plan.size(); k++) begin
			if (plan[k].is_policy) begin
				write_policy(plan[k].policy);
			end else begin
				for (r = 0; r < plan[k].reps; r++)
					offer(plan[k].fn, plan[k].addr - addr_t'(r * 256), plan[k].len,
						plan[k].tag + TAG_W'(r), plan[k].pinned, plan[k].want);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			write_policy(POL_W'($urandom_range(0, 3)));
			phase_end = sent + $urandom_range(20, 60);
			while (sent < phase_end) begin
				if (sent == 150)
					hold_ask = 1'b1;
				// keep the table moving between nearly empty and full
				if (free_count >= MAX_HOLES - 2)
					load_pct = 25;
				else if (free_count < 4)
					load_pct = 75;
				else
					load_pct = 50;
				fn = ($urandom_range(0, 99) < load_pct) ? FUNC_LOAD : FUNC_ALLOC;
				a  = addr_t'($urandom);
				t  = TAG_W'($urandom);
				if (fn == FUNC_LOAD) begin
					case ($urandom_range(0, 9))
						0: l = '0;
						1, 2: l = len_t'($urandom);
						default: l = len_t'($urandom_range(1, 64));
					endcase
				end else begin
					case ($urandom_range(0, 19))
						0: l = '0;
						1: l = '1;
						2, 3: l = len_t'($urandom);
						4, 5, 6, 7, 8, 9, 10, 11: begin
							// exact size of a live hole, so holes get removed
							if (free_count > 0)
								l = free_size[$urandom_range(0, free_count - 1)];
							else
								l = len_t'($urandom_range(1, 64));
						end
						default: l = len_t'($urandom_range(1, 64));
					endcase
				end
				offer(fn, a, l, t, 1'b0, '0);
				sent++;
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
